// ----- design/tst_pkg.sv -----
// Package for the track state table: sizes, state codes, mode codes and the
// structs that pass between the top level and the table cells.
// No dependencies.
package tst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 32;
    localparam int CFG_W       = 5;
    localparam int RESET_ACTIVE_ENTRIES = 10;

    typedef logic [1:0]      trk_state_t;
    typedef logic [ID_W-1:0] trk_id_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam trk_state_t ST_REJECT   = 2'd0;
    localparam trk_state_t ST_DOING    = 2'd1;
    localparam trk_state_t ST_PASS     = 2'd2;
    localparam trk_state_t ST_STRANGER = 2'd3;

    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Per-cell control from the top level.
    typedef struct packed {
        logic live;     // cell holds a valid entry (index below fill count)
        logic load;     // take id/state from the newer neighbor
        logic upd_en;   // update item in progress
    } cell_ctrl_t;

    // Lookup result rippling from newest cell to oldest.
    typedef struct packed {
        logic       hit;
        trk_state_t state;
    } lookup_t;

endpackage

// ----- design/tst_cell.sv -----
// One entry of the track state table: id and state registers, compare
// against the broadcast key, and the shift path from the newer neighbor.
// Depends on tst_pkg.
module tst_cell
    import tst_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  trk_id_t    key_id,
    input  trk_state_t wr_state,
    input  trk_id_t    prev_id,
    input  trk_state_t prev_state,
    input  lookup_t    chain_in,
    output trk_id_t    id,
    output trk_state_t state,
    output lookup_t    chain_out
);

    trk_id_t    id_reg;
    trk_state_t state_reg;
    logic       match;
    logic       newest_hit;

    assign match      = ctrl.live && (id_reg == key_id);
    // newest match wins: only the first matching cell along the chain counts
    assign newest_hit = match && !chain_in.hit;

    always_comb
    begin
        chain_out.hit   = chain_in.hit | match;
        chain_out.state = newest_hit ? state_reg : chain_in.state;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            id_reg    <= prev_id;
            state_reg <= prev_state;
        end
        else if (ctrl.upd_en && newest_hit)
        begin
            state_reg <= wr_state;
        end
    end

    assign id    = id_reg;
    assign state = state_reg;

endmodule

// ----- design/track_state_table.sv -----
// track_state_table: table of recently seen track ids with a 2-bit state.
// Input channel (in_valid / in_stall): mode, face_id, new_state. An item is
// taken when in_valid is high and in_stall low. Mode check looks the id up;
// a miss inserts it as newest with state doing, evicting the oldest entries
// beyond the capacity, active_entries clamped to 1..16. Mode update rewrites
// the state of the newest matching entry.
// Output channel (out_valid / out_stall): needs_work, found, one item per
// input item, in order.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_data writes
// active_entries; write it only while the block is idle.
// Timing: an item is registered in the key register when it is taken, then
// looked up and applied, with the result in the output register that drives
// out_valid. A new item is taken only once the key register has passed its
// item on, limited by the single key register ahead of the cell row whose
// hit ripple and shift are combinational.
// When out_stall holds a result, the next item still waits in the key
// register and in_stall stays high until the result leaves.
// Reset empties the table (fill count zero) and sets active_entries to 10;
// entry contents are not cleared.
module track_state_table
    import tst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic [ID_W-1:0]  face_id,
    input  logic [1:0]       new_state,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             needs_work,
    output logic             found,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic             key_valid_reg, key_valid_next;
    logic             key_mode_reg;
    trk_id_t          key_id_reg;
    trk_state_t       key_state_reg;
    logic [CFG_W-1:0] active_entries_reg;
    count_t           fill_count_reg, fill_count_next;
    logic             out_valid_reg, out_valid_next;
    logic             needs_work_reg, found_reg;

    logic       process;
    logic       do_insert;
    count_t     cap;
    count_t     keep;
    lookup_t    chain [0:MAX_ENTRIES];
    cell_ctrl_t ctrl  [MAX_ENTRIES];
    trk_id_t    cell_id    [MAX_ENTRIES];
    trk_state_t cell_state [MAX_ENTRIES];

    assign in_stall  = key_valid_reg;
    assign cfg_ready = 1'b1;
    assign process   = key_valid_reg && (!out_valid_reg || !out_stall);
    assign do_insert = process && (key_mode_reg == MODE_CHECK) && !chain[MAX_ENTRIES].hit;

    // capacity clamped to 1..MAX_ENTRIES
    always_comb
    begin
        priority if (active_entries_reg == '0)
            cap = count_t'(1);
        else if (int'(active_entries_reg) > MAX_ENTRIES)
            cap = count_t'(MAX_ENTRIES);
        else
            cap = count_t'(active_entries_reg);
        keep = (fill_count_reg > cap - count_t'(1)) ? cap - count_t'(1) : fill_count_reg;
    end

    assign chain[0] = '{hit: 1'b0, state: ST_REJECT};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign ctrl[gi] = '{live:   count_t'(gi) < fill_count_reg,
                                load:   do_insert && (count_t'(gi) <= keep),
                                upd_en: process && (key_mode_reg == MODE_UPDATE)};

            if (gi == 0)
            begin : g_head
                // newest cell loads the key itself on an insert
                tst_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[gi]),
                    .key_id     (key_id_reg),
                    .wr_state   (key_state_reg),
                    .prev_id    (key_id_reg),
                    .prev_state (ST_DOING),
                    .chain_in   (chain[gi]),
                    .id         (cell_id[gi]),
                    .state      (cell_state[gi]),
                    .chain_out  (chain[gi+1])
                );
            end
            else
            begin : g_body
                tst_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[gi]),
                    .key_id     (key_id_reg),
                    .wr_state   (key_state_reg),
                    .prev_id    (cell_id[gi-1]),
                    .prev_state (cell_state[gi-1]),
                    .chain_in   (chain[gi]),
                    .id         (cell_id[gi]),
                    .state      (cell_state[gi]),
                    .chain_out  (chain[gi+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (process)
            key_valid_next = 1'b0;
        else if (in_valid && !in_stall)
            key_valid_next = 1'b1;

        fill_count_next = do_insert ? keep + count_t'(1) : fill_count_reg;

        out_valid_next = out_valid_reg;
        if (process)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            fill_count_reg     <= '0;
            active_entries_reg <= CFG_W'(RESET_ACTIVE_ENTRIES);
        end
        else
        begin
            key_valid_reg  <= key_valid_next;
            out_valid_reg  <= out_valid_next;
            fill_count_reg <= fill_count_next;
            if (cfg_valid && cfg_ready)
                active_entries_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            key_mode_reg  <= mode;
            key_id_reg    <= face_id;
            key_state_reg <= new_state;
        end
        if (process)
        begin
            found_reg <= chain[MAX_ENTRIES].hit;
            if (key_mode_reg == MODE_UPDATE)
                needs_work_reg <= 1'b0;
            else
                needs_work_reg <= !chain[MAX_ENTRIES].hit
                                  || (chain[MAX_ENTRIES].state == ST_REJECT);
        end
    end

    assign out_valid  = out_valid_reg;
    assign needs_work = needs_work_reg;
    assign found      = found_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_count_reg) <= MAX_ENTRIES)
        else $error("fill count beyond table depth");

    a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (cell_id[0] == $past(key_id_reg)) && (cell_state[0] == ST_DOING)
                      && (fill_count_reg != '0))
        else $error("insert did not land in newest cell");

    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        (process && key_mode_reg == MODE_UPDATE) |=> out_valid_reg && !needs_work_reg)
        else $error("update item flagged needs_work");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !process)
        else $error("result overwritten while stalled");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for track_state_table: directed and random check and
// update items against a behavioral table model. Depends on tst_pkg and the RTL.
module tb;
    import tst_pkg::*;

    localparam int POOL_SIZE   = 24;
    localparam int NUM_PHASES  = 8;
    localparam int DRAIN_TICKS = 4;

    typedef struct {
        logic       mode;
        trk_id_t    id;
        trk_state_t st;
    } track_item_t;

    typedef struct {
        logic needs_work;
        logic found;
    } verdict_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             mode = MODE_CHECK;
    logic [ID_W-1:0]  face_id = '0;
    logic [1:0]       new_state = ST_REJECT;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             needs_work;
    logic             found;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // table model
    trk_id_t          model_ids [MAX_ENTRIES];
    trk_state_t       model_states [MAX_ENTRIES];
    int               model_fill = 0;
    logic [CFG_W-1:0] model_active = CFG_W'(RESET_ACTIVE_ENTRIES);

    track_item_t track_items_q [$];
    verdict_t    expected_verdicts [$];
    trk_id_t     id_pool [POOL_SIZE];
    int          pool_span = POOL_SIZE;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;

    track_state_table uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .face_id    (face_id),
        .new_state  (new_state),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .needs_work (needs_work),
        .found      (found),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Finds the newest matching entry, applies the item to the table and returns
    // the verdict the block should give.
    function automatic verdict_t apply_track_item(input track_item_t it);
        verdict_t v;
        int       hit;
        int       cap;
        int       keep;
        hit = -1;
        for (int i = model_fill - 1; i >= 0; i--)
            if (model_ids[i] == it.id)
                hit = i;
        v.found = (hit >= 0);
        if (it.mode == MODE_UPDATE) begin
            if (hit >= 0)
                model_states[hit] = it.st;
            v.needs_work = 1'b0;
        end else if (hit >= 0) begin
            v.needs_work = (model_states[hit] == ST_REJECT);
        end else begin
            cap = int'(model_active);
            if (cap < 1)
                cap = 1;
            if (cap > MAX_ENTRIES)
                cap = MAX_ENTRIES;
            // a lowered capacity trims the table here, on the next miss
            keep = (model_fill > cap - 1) ? cap - 1 : model_fill;
            for (int i = keep; i > 0; i--) begin
                model_ids[i]    = model_ids[i-1];
                model_states[i] = model_states[i-1];
            end
            model_ids[0]    = it.id;
            model_states[0] = ST_DOING;
            model_fill      = keep + 1;
            v.needs_work    = 1'b1;
        end
        return v;
    endfunction

    function automatic track_item_t random_track_item();
        track_item_t it;
        it.mode = ($urandom_range(99) < 35) ? MODE_UPDATE : MODE_CHECK;
        if ($urandom_range(9) == 0)
            it.id = trk_id_t'($urandom);
        else
            it.id = id_pool[$urandom_range(pool_span - 1)];
        it.st = trk_state_t'($urandom_range(3));
        return it;
    endfunction

    task automatic queue_item(input logic m, input trk_id_t id, input trk_state_t st);
        track_item_t it;
        it.mode = m;
        it.id   = id;
        it.st   = st;
        track_items_q.push_back(it);
    endtask

    // sampled at the falling edge, after the driver and monitor have settled
    task automatic wait_idle();
        @(negedge clk);
        while (track_items_q.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
    endtask

    task automatic write_active_entries(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        model_active = value;
    endtask

    // driver: predicts at acceptance, then loads the next pending item
    always @(posedge clk) begin
        logic        load_next;
        track_item_t taken;
        track_item_t nxt;
        load_next = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                taken.mode = mode;
                taken.id   = face_id;
                taken.st   = new_state;
                expected_verdicts.push_back(apply_track_item(taken));
            end
            if (!in_valid || !in_stall) begin
                if (track_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                    load_next = 1'b1;
                if (load_next) begin
                    nxt = track_items_q.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= nxt.mode;
                    face_id   <= nxt.id;
                    new_state <= nxt.st;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result with the oldest prediction
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result needs_work=%0b found=%0b",
                         $time, needs_work, found);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (needs_work !== want.needs_work) begin
                    $display("%0t: needs_work expected %0b actual %0b",
                             $time, want.needs_work, needs_work);
                    errors++;
                end
                if (found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, found);
                    errors++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int phase_cfg [NUM_PHASES] = '{-1, 16, 3, 1, 0, 31, 5, -2};
        int phase_send [NUM_PHASES] = '{0, 86, 0, 15, 0, 86, 0, 15};
        int phase_recv [NUM_PHASES] = '{0, 0, 86, 15, 0, 0, 86, 15};
        int cap;

        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            id_pool[i] = trk_id_t'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, every state on a hit, extreme ids, eviction
        queue_item(MODE_UPDATE, 32'h0000_0000, ST_PASS);
        queue_item(MODE_CHECK,  32'h0000_0000, ST_STRANGER);
        queue_item(MODE_CHECK,  32'h0000_0000, ST_REJECT);
        queue_item(MODE_UPDATE, 32'h0000_0000, ST_REJECT);
        queue_item(MODE_CHECK,  32'h0000_0000, ST_PASS);
        queue_item(MODE_UPDATE, 32'h0000_0000, ST_PASS);
        queue_item(MODE_CHECK,  32'h0000_0000, ST_REJECT);
        queue_item(MODE_UPDATE, 32'h0000_0000, ST_STRANGER);
        queue_item(MODE_CHECK,  32'h0000_0000, ST_REJECT);
        queue_item(MODE_UPDATE, 32'h0000_0000, ST_DOING);
        queue_item(MODE_CHECK,  32'hFFFF_FFFF, ST_STRANGER);
        queue_item(MODE_CHECK,  32'h8000_0000, ST_REJECT);
        queue_item(MODE_CHECK,  32'h7FFF_FFFF, ST_REJECT);
        for (int i = 1; i <= 7; i++)
            queue_item(MODE_CHECK, trk_id_t'(i), ST_REJECT);
        // eleven ids exceed the reset capacity of ten; the first id has gone out
        queue_item(MODE_CHECK,  32'h0000_0000, ST_REJECT);
        queue_item(MODE_UPDATE, 32'hFFFF_FFFF, ST_REJECT);
        queue_item(MODE_CHECK,  32'hFFFF_FFFF, ST_PASS);
        queue_item(MODE_UPDATE, 32'h8000_0000, ST_PASS);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (phase_cfg[p] != -1) begin
                wait_idle();
                if (phase_cfg[p] == -2)
                    write_active_entries(CFG_W'($urandom_range(31)));
                else
                    write_active_entries(CFG_W'(phase_cfg[p]));
            end
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            cap = (model_active == 0) ? 1 : int'(model_active);
            pool_span = (cap + 4 > POOL_SIZE) ? POOL_SIZE : cap + 4;
            for (int i = 0; i < 6; i++)
                id_pool[$urandom_range(POOL_SIZE - 1, 4)] = trk_id_t'($urandom);
            for (int i = 0; i < 180; i++)
                track_items_q.push_back(random_track_item());
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
